@@ design/lgb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lgb_pkg;

    localparam int FRAC_BITS   = 14;
    localparam int COORD_W     = 16;
    localparam int VALUE_W     = 16;
    localparam int INDEX_W     = 4;
    localparam int ORDER_W     = 4;
    localparam int MAX_ORDER   = 15;
    localparam int ONE_Q       = 1 << FRAC_BITS;

    localparam int MUL_W       = 27;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = 36;
    localparam int QUO_W       = 22;
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 26;

    typedef logic signed [MUL_W-1:0]  mul_op_t;
    typedef logic signed [PROD_W-1:0] mul_prod_t;

    // ceil(2^RECIP_SHIFT / k); exact floor division for quotients below 2^QUO_W
    function automatic logic [RECIP_W-1:0] recip(input logic [INDEX_W-1:0] k);
        logic [RECIP_W-1:0] r;
        begin
            case (k)
                4'd2:    r = 26'd33554432;
                4'd3:    r = 26'd22369622;
                4'd4:    r = 26'd16777216;
                4'd5:    r = 26'd13421773;
                4'd6:    r = 26'd11184811;
                4'd7:    r = 26'd9586981;
                4'd8:    r = 26'd8388608;
                4'd9:    r = 26'd7456541;
                4'd10:   r = 26'd6710887;
                4'd11:   r = 26'd6100806;
                4'd12:   r = 26'd5592406;
                4'd13:   r = 26'd5162221;
                4'd14:   r = 26'd4793491;
                4'd15:   r = 26'd4473925;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

@@ design/lgb_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lgb_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [lgb_pkg::COORD_W-1:0] coord;
    logic                               reversed;

    modport source (output valid, output coord, output reversed, input ready);
    modport sink   (input valid, input coord, input reversed, output ready);
endinterface

`default_nettype wire

@@ design/lgb_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lgb_out_if;
    logic                               valid;
    logic                               ready;
    logic [lgb_pkg::INDEX_W-1:0]        func_index;
    logic signed [lgb_pkg::VALUE_W-1:0] basis_value;
    logic                               last;

    modport source (output valid, output func_index, output basis_value, output last,
                    input ready);
    modport sink   (input valid, input func_index, input basis_value, input last,
                    output ready);
endinterface

`default_nettype wire

@@ design/legendre_edge_basis_generator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Emits P_0(u) .. P_n(u) (Legendre polynomials, Q2.14, saturated to +-1.0) for each
// accepted coordinate, n = order register, with even indices negated when reversed
// is set and last marking index n. One coordinate is taken at a time; the next one is
// accepted only after index n has been loaded into the output register, and output
// stalls hold the sequence. Each index from 2 up takes four passes through one
// shared 27x27 multiplier (two recurrence products, the P(k-2) term, and a reciprocal
// multiply that divides by k), a rounding step, saturation, and the output load. The
// last result may still wait in the output register while the next coordinate is
// taken.
module legendre_edge_basis_generator_core
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_we,
    input  wire [lgb_pkg::ORDER_W-1:0]    cfg_wdata,
    lgb_in_if.sink                        sample,
    lgb_out_if.source                     basis
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EMIT = 3'd1;
    localparam logic [2:0] S_MA   = 3'd2;
    localparam logic [2:0] S_MB   = 3'd3;
    localparam logic [2:0] S_MC   = 3'd4;
    localparam logic [2:0] S_DV   = 3'd5;
    localparam logic [2:0] S_MD   = 3'd6;
    localparam logic [2:0] S_SAT  = 3'd7;

    localparam int VW = lgb_pkg::VALUE_W;
    localparam int IW = lgb_pkg::INDEX_W;
    localparam int AW = lgb_pkg::ACC_W;
    localparam int QW = lgb_pkg::QUO_W;
    localparam int FB = lgb_pkg::FRAC_BITS;

    localparam logic signed [VW-1:0] ONE_V   = VW'(lgb_pkg::ONE_Q);
    localparam logic signed [VW-1:0] M_ONE_V = -ONE_V;

    logic [2:0]                   state_reg, state_next;
    logic [IW-1:0]                k_reg, k_next;
    logic [IW-1:0]                n_reg, n_next;
    logic [lgb_pkg::ORDER_W-1:0]  order_reg;
    logic                         out_valid_reg, out_valid_next;

    logic signed [VW-1:0]         coord_reg, prev_reg, pp_reg;
    logic                         rev_reg;
    logic signed [AW-1:0]         acc_reg;
    logic [QW-1:0]                m_reg;
    logic                         neg_reg;
    logic [IW-1:0]                out_index_reg;
    logic signed [VW-1:0]         out_value_reg;
    logic                         out_last_reg;

    lgb_pkg::mul_op_t             mul_a, mul_b;
    lgb_pkg::mul_prod_t           mul_p;
    logic                         mul_en;

    logic                         accept, out_free, load;
    logic [IW:0]                  odd_k;
    logic [IW-1:0]                km1;
    logic signed [20:0]           t_u;
    logic signed [AW-1:0]         term2, num;
    logic [AW-1:0]                mag, rsum;
    logic [QW-1:0]                quo;
    logic signed [VW-1:0]         sat_val, clamp_u, shown;

    assign accept   = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || basis.ready;
    assign load     = (state_reg == S_EMIT) && out_free;

    assign odd_k = {k_reg, 1'b0} - (IW+1)'(1);
    assign km1   = k_reg - IW'(1);
    assign t_u   = signed'(mul_p[20:0]);

    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            S_MA:
            begin
                mul_en = 1'b1;
                mul_a  = lgb_pkg::mul_op_t'(coord_reg);
                mul_b  = lgb_pkg::mul_op_t'(odd_k);
            end
            S_MB:
            begin
                mul_en = 1'b1;
                mul_a  = lgb_pkg::mul_op_t'(t_u);
                mul_b  = lgb_pkg::mul_op_t'(prev_reg);
            end
            S_MC:
            begin
                mul_en = 1'b1;
                mul_a  = lgb_pkg::mul_op_t'(km1);
                mul_b  = lgb_pkg::mul_op_t'(pp_reg);
            end
            S_MD:
            begin
                mul_en = 1'b1;
                mul_a  = lgb_pkg::mul_op_t'(m_reg);
                mul_b  = lgb_pkg::mul_op_t'(lgb_pkg::recip(k_reg));
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    lgb_mul u_mul
    (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    // numerator at 2*FRAC_BITS fraction bits, round half away from zero by k*2^FRAC_BITS
    assign term2 = signed'(mul_p[AW-1:0]) <<< FB;
    assign num   = acc_reg - term2;
    assign mag   = num[AW-1] ? AW'(-num) : AW'(num);
    assign rsum  = mag + (AW'(k_reg) << (FB - 1));

    assign quo     = mul_p[lgb_pkg::RECIP_SHIFT +: QW];
    assign sat_val = (quo > QW'(lgb_pkg::ONE_Q)) ? ONE_V : VW'(quo);

    assign clamp_u = (coord_reg > ONE_V) ? ONE_V :
                     (coord_reg < M_ONE_V) ? M_ONE_V : coord_reg;

    assign shown = (rev_reg && !k_reg[0]) ? -prev_reg : prev_reg;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg;
        if (basis.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = S_EMIT;
                    k_next     = '0;
                    n_next     = (order_reg > IW'(lgb_pkg::MAX_ORDER)) ?
                                 IW'(lgb_pkg::MAX_ORDER) : order_reg;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (k_reg == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + IW'(1);
                        if (k_reg != '0)
                        begin
                            state_next = S_MA;
                        end
                    end
                end
            end
            S_MA:    state_next = S_MB;
            S_MB:    state_next = S_MC;
            S_MC:    state_next = S_DV;
            S_DV:    state_next = S_MD;
            S_MD:    state_next = S_SAT;
            S_SAT:   state_next = S_EMIT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
            order_reg     <= lgb_pkg::ORDER_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                order_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coord_reg <= sample.coord;
            rev_reg   <= sample.reversed;
            prev_reg  <= ONE_V;
            pp_reg    <= '0;
        end
        if (load && (k_reg == '0) && (k_reg != n_reg))
        begin
            prev_reg <= clamp_u;
            pp_reg   <= prev_reg;
        end
        if (state_reg == S_MC)
        begin
            acc_reg <= signed'(mul_p[AW-1:0]);
        end
        if (state_reg == S_DV)
        begin
            m_reg   <= rsum[AW-1:FB];
            neg_reg <= num[AW-1];
        end
        if (state_reg == S_SAT)
        begin
            prev_reg <= neg_reg ? -sat_val : sat_val;
            pp_reg   <= prev_reg;
        end
        if (load)
        begin
            out_index_reg <= k_reg;
            out_value_reg <= shown;
            out_last_reg  <= (k_reg == n_reg);
        end
    end

    assign sample.ready      = (state_reg == S_IDLE);
    assign basis.valid       = out_valid_reg;
    assign basis.func_index  = out_index_reg;
    assign basis.basis_value = out_value_reg;
    assign basis.last        = out_last_reg;

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        basis.valid |-> (basis.basis_value <= ONE_V && basis.basis_value >= M_ONE_V))
        else $error("result outside +-1.0");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EMIT && k_reg == '0))
        else $error("item accepted without starting at index 0");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (k_reg <= n_reg))
        else $error("index ran past order");

    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        (basis.valid && basis.ready && !basis.last) |-> (state_reg != S_IDLE))
        else $error("idle before last result");

endmodule

`default_nettype wire

@@ design/lgb_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lgb_mul
(
    input  wire                     clk,
    input  wire                     en,
    input  wire lgb_pkg::mul_op_t   a,
    input  wire lgb_pkg::mul_op_t   b,
    output lgb_pkg::mul_prod_t      prod
);

    lgb_pkg::mul_prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire
